[rtl/gbf_pkg.sv]
// Shared types and constants for the graph bridge finder.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none
package gbf_pkg;
    localparam int MAX_VERTICES = 32;
    localparam int MAX_ENTRIES  = 64;
    localparam int VTX_W   = $clog2(MAX_VERTICES);
    localparam int NCNT_W  = VTX_W + 1;
    localparam int ENT_W   = $clog2(MAX_ENTRIES);
    localparam int CNT_W   = ENT_W + 1;

    typedef logic [VTX_W-1:0]  vtx_t;
    typedef logic [NCNT_W-1:0] ncnt_t;
    typedef logic [ENT_W-1:0]  ent_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    typedef struct packed {
        logic [4:0] source_vertex;
        logic [4:0] neighbor_vertex;
        logic       last_entry;
    } in_word_t;

    typedef struct packed {
        logic [4:0] source_vertex_out;
        logic [4:0] neighbor_vertex_out;
        logic       kept;
        logic       overflow;
        logic       last_result;
    } out_word_t;

    typedef struct packed {
        vtx_t src;
        vtx_t nb;
    } entry_t;

    typedef struct packed {
        vtx_t disc;
        vtx_t low;
        vtx_t par;
    } vrec_t;

    typedef struct packed {
        logic  we;
        vtx_t  waddr;
        vrec_t wdata;
        vtx_t  raddr;
    } vram_req_t;
endpackage
`default_nettype wire

[rtl/gbf_entry_ram.sv]
// Adjacency entry store: one write port, one registered read port.
// Depends on gbf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gbf_entry_ram (
    input  wire logic            aclk,
    input  wire logic            we,
    input  wire gbf_pkg::ent_t   waddr,
    input  wire gbf_pkg::entry_t wdata,
    input  wire gbf_pkg::ent_t   raddr,
    output gbf_pkg::entry_t      rdata
);
    import gbf_pkg::*;

    entry_t mem [MAX_ENTRIES];
    entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

[rtl/gbf_vertex_ram.sv]
// Per-vertex record store (discovery order, lowlink, tree parent).
// Depends on gbf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gbf_vertex_ram (
    input  wire logic               aclk,
    input  wire gbf_pkg::vram_req_t req,
    output gbf_pkg::vrec_t          rdata
);
    import gbf_pkg::*;

    vrec_t mem [MAX_VERTICES];
    vrec_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

[rtl/gbf_walk.sv]
// Depth-first walk engine with explicit stack memory and cached stack top.
// Depends on gbf_pkg; drives the entry and vertex stores through the top level.
`timescale 1ns / 1ps
`default_nettype none
module gbf_walk (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            start,
    input  wire gbf_pkg::ncnt_t  vtx_cnt,
    input  wire gbf_pkg::cnt_t   ent_count,
    input  wire gbf_pkg::entry_t ent_rdata,
    output gbf_pkg::ent_t        ent_raddr,
    output gbf_pkg::vram_req_t   vreq,
    input  wire gbf_pkg::vrec_t  vram_rdata,
    output logic                 done
);
    import gbf_pkg::*;

    typedef enum logic [6:0] {
        W_IDLE = 7'b0000001,
        W_ROOT = 7'b0000010,
        W_SCAN = 7'b0000100,
        W_CHK  = 7'b0001000,
        W_BACK = 7'b0010000,
        W_POP2 = 7'b0100000,
        W_DONE = 7'b1000000
    } wstate_t;

    typedef struct packed {
        vtx_t v;
        cnt_t i;
    } stk_t;

    wstate_t state_reg;
    ncnt_t   r_reg, order_reg, depth_reg;
    cnt_t    idx_reg;
    vtx_t    top_v_reg, disc_reg, low_reg, par_reg, w_reg, child_low_reg;
    logic [MAX_VERTICES-1:0] visited_reg;
    stk_t    stack_mem [MAX_VERTICES];
    stk_t    stk_rd_reg;
    vtx_t    stk_raddr;

    logic pop_go, hit, push_go, back_go;

    assign pop_go  = (state_reg == W_SCAN) && (idx_reg >= ent_count);
    assign hit     = (state_reg == W_CHK) && (ent_rdata.src == top_v_reg)
                     && ({1'b0, ent_rdata.nb} < vtx_cnt);
    assign push_go = hit && !visited_reg[ent_rdata.nb];
    assign back_go = hit && visited_reg[ent_rdata.nb] && (ent_rdata.nb != top_v_reg);
    assign stk_raddr = VTX_W'(depth_reg - NCNT_W'(2));

    assign ent_raddr = idx_reg[ENT_W-1:0];
    assign done      = (state_reg == W_DONE);

    always_comb begin
        vreq.we    = pop_go || push_go;
        vreq.waddr = top_v_reg;
        vreq.wdata = '{disc: disc_reg, low: low_reg, par: par_reg};
        vreq.raddr = pop_go ? par_reg : ent_rdata.nb;
    end

    // Stack store: push saves the old top, pop reads the new one.
    always_ff @(posedge aclk) begin
        if (push_go) begin
            stack_mem[VTX_W'(depth_reg - NCNT_W'(1))] <= '{v: top_v_reg, i: idx_reg + CNT_W'(1)};
        end
        stk_rd_reg <= stack_mem[stk_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= W_IDLE;
            visited_reg <= '0;
            r_reg       <= '0;
            order_reg   <= '0;
            depth_reg   <= '0;
            idx_reg     <= '0;
        end else begin
            unique case (state_reg)
                W_IDLE: begin
                    if (start) begin
                        visited_reg <= '0;
                        order_reg   <= '0;
                        r_reg       <= '0;
                        state_reg   <= W_ROOT;
                    end
                end
                W_ROOT: begin
                    if (r_reg >= vtx_cnt) begin
                        state_reg <= W_DONE;
                    end else if (visited_reg[r_reg[VTX_W-1:0]]) begin
                        r_reg <= r_reg + NCNT_W'(1);
                    end else begin
                        top_v_reg <= r_reg[VTX_W-1:0];
                        disc_reg  <= order_reg[VTX_W-1:0];
                        low_reg   <= order_reg[VTX_W-1:0];
                        par_reg   <= r_reg[VTX_W-1:0];
                        idx_reg   <= '0;
                        depth_reg <= NCNT_W'(1);
                        order_reg <= order_reg + NCNT_W'(1);
                        visited_reg[r_reg[VTX_W-1:0]] <= 1'b1;
                        state_reg <= W_SCAN;
                    end
                end
                W_SCAN: begin
                    if (pop_go) begin
                        child_low_reg <= low_reg;
                        depth_reg     <= depth_reg - NCNT_W'(1);
                        if (depth_reg == NCNT_W'(1)) begin
                            r_reg     <= r_reg + NCNT_W'(1);
                            state_reg <= W_ROOT;
                        end else begin
                            state_reg <= W_POP2;
                        end
                    end else begin
                        state_reg <= W_CHK;
                    end
                end
                W_CHK: begin
                    w_reg <= ent_rdata.nb;
                    if (push_go) begin
                        top_v_reg <= ent_rdata.nb;
                        disc_reg  <= order_reg[VTX_W-1:0];
                        low_reg   <= order_reg[VTX_W-1:0];
                        par_reg   <= top_v_reg;
                        idx_reg   <= '0;
                        depth_reg <= depth_reg + NCNT_W'(1);
                        order_reg <= order_reg + NCNT_W'(1);
                        visited_reg[ent_rdata.nb] <= 1'b1;
                        state_reg <= W_SCAN;
                    end else begin
                        idx_reg   <= idx_reg + CNT_W'(1);
                        state_reg <= back_go ? W_BACK : W_SCAN;
                    end
                end
                W_BACK: begin
                    // Parallel edge to the parent does not count as a back edge.
                    if (par_reg != w_reg && vram_rdata.disc < low_reg) begin
                        low_reg <= vram_rdata.disc;
                    end
                    state_reg <= W_SCAN;
                end
                W_POP2: begin
                    top_v_reg <= stk_rd_reg.v;
                    idx_reg   <= stk_rd_reg.i;
                    disc_reg  <= vram_rdata.disc;
                    par_reg   <= vram_rdata.par;
                    low_reg   <= (child_low_reg < vram_rdata.low) ? child_low_reg
                                                                  : vram_rdata.low;
                    state_reg <= W_SCAN;
                end
                W_DONE: begin
                    state_reg <= W_IDLE;
                end
                default: state_reg <= W_IDLE;
            endcase
        end
    end

    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= NCNT_W'(MAX_VERTICES))
        else $error("walk stack deeper than vertex count");
    a_scan_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == W_SCAN || state_reg == W_CHK) |-> depth_reg != '0)
        else $error("scan with empty stack");
    a_push_order: assert property (@(posedge aclk) disable iff (!aresetn)
        push_go |=> order_reg == $past(order_reg) + NCNT_W'(1))
        else $error("discovery order did not advance on push");
endmodule
`default_nettype wire

[rtl/graph_bridge_finder_core.sv]
// Top level of the bridge finder: load, walk control, replay and output register.
// Depends on gbf_pkg, gbf_entry_ram, gbf_vertex_ram and gbf_walk.
`timescale 1ns / 1ps
`default_nettype none
// Bridge finder for an undirected graph. Adjacency words (source, neighbor,
// last flag) are taken one per cycle into a 64-entry store; words beyond that
// are dropped and every result of the graph then carries overflow. After the
// last word the block runs a depth-first walk from each vertex below
// vertex_count (capped at 32) and then replays every stored entry in arrival
// order, one result word each, kept low for a bridge. s_ready is low from the
// last word until the final result is taken. For each vertex whose list is
// scanned, the walk reads the registered entry store once per stored entry,
// and each vertex also needs pushes, pops and lowlink updates through the
// vertex store. Each replayed result takes an entry read, two vertex reads,
// a compare and the output handshake, plus any output stall. vertex_count
// must be written only while the block is idle; the block itself does not
// enforce this.
module graph_bridge_finder_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [5:0]        cfg_wr_data,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire gbf_pkg::in_word_t s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output gbf_pkg::out_word_t     m_data
);
    import gbf_pkg::*;

    typedef enum logic [6:0] {
        T_LOAD = 7'b0000001,
        T_WALK = 7'b0000010,
        T_RE   = 7'b0000100,
        T_RA   = 7'b0001000,
        T_RB   = 7'b0010000,
        T_RC   = 7'b0100000,
        T_OUT  = 7'b1000000
    } tstate_t;

    tstate_t   state_reg;
    logic [5:0] vcount_reg;
    cnt_t      count_reg;
    logic      dropped_reg;
    ent_t      k_reg;
    vtx_t      a_reg, b_reg;
    vrec_t     rec_a_reg;
    logic      m_valid_reg;
    out_word_t m_data_reg;

    ncnt_t     n_eff;
    logic      in_acc, store_en, walk_start, walk_done;
    ent_t      walk_raddr, ent_raddr;
    entry_t    ent_wdata;
    entry_t    ent_rdata;
    vram_req_t walk_vreq, vreq;
    vrec_t     vram_rdata;
    logic      kept_c, last_c;

    // Cap the vertex count at the store size.
    assign n_eff = (vcount_reg > 6'(MAX_VERTICES)) ? NCNT_W'(MAX_VERTICES)
                                                   : NCNT_W'(vcount_reg);

    assign s_ready    = (state_reg == T_LOAD);
    assign in_acc     = s_valid && s_ready;
    assign store_en   = in_acc && (count_reg < CNT_W'(MAX_ENTRIES));
    assign walk_start = in_acc && s_data.last_entry;

    assign ent_raddr = (state_reg == T_WALK) ? walk_raddr : k_reg;
    assign ent_wdata = '{src: s_data.source_vertex, nb: s_data.neighbor_vertex};

    gbf_entry_ram u_entries (
        .aclk  (aclk),
        .we    (store_en),
        .waddr (count_reg[ENT_W-1:0]),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    // The walk owns the vertex store while it runs; replay only reads it.
    always_comb begin
        vreq       = walk_vreq;
        if (state_reg != T_WALK) begin
            vreq.we    = 1'b0;
            vreq.raddr = (state_reg == T_RA) ? ent_rdata.src : b_reg;
        end
    end

    gbf_vertex_ram u_vertices (
        .aclk  (aclk),
        .req   (vreq),
        .rdata (vram_rdata)
    );

    gbf_walk u_walk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (walk_start),
        .vtx_cnt    (n_eff),
        .ent_count  (count_reg),
        .ent_rdata  (ent_rdata),
        .ent_raddr  (walk_raddr),
        .vreq       (walk_vreq),
        .vram_rdata (vram_rdata),
        .done       (walk_done)
    );

    // Bridge test: a tree edge whose child's lowlink exceeds the parent's order.
    always_comb begin
        kept_c = 1'b1;
        if ({1'b0, a_reg} < n_eff && {1'b0, b_reg} < n_eff) begin
            if (rec_a_reg.par == b_reg) begin
                kept_c = !(vram_rdata.disc < rec_a_reg.low);
            end else if (vram_rdata.par == a_reg) begin
                kept_c = !(rec_a_reg.disc < vram_rdata.low);
            end
        end
    end

    assign last_c = (CNT_W'(k_reg) + CNT_W'(1)) == count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_LOAD;
            vcount_reg  <= 6'(MAX_VERTICES);
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                vcount_reg <= cfg_wr_data;
            end
            unique case (state_reg)
                T_LOAD: begin
                    // Store the word, or drop it once the store is full.
                    if (in_acc) begin
                        if (store_en) begin
                            count_reg <= count_reg + CNT_W'(1);
                        end else begin
                            dropped_reg <= 1'b1;
                        end
                        if (s_data.last_entry) begin
                            state_reg <= T_WALK;
                        end
                    end
                end
                T_WALK: begin
                    if (walk_done) begin
                        k_reg     <= '0;
                        state_reg <= T_RE;
                    end
                end
                T_RE: state_reg <= T_RA;
                T_RA: begin
                    a_reg     <= ent_rdata.src;
                    b_reg     <= ent_rdata.nb;
                    state_reg <= T_RB;
                end
                T_RB: begin
                    rec_a_reg <= vram_rdata;
                    state_reg <= T_RC;
                end
                T_RC: begin
                    m_data_reg  <= '{source_vertex_out:   a_reg,
                                     neighbor_vertex_out: b_reg,
                                     kept:                kept_c,
                                     overflow:            dropped_reg,
                                     last_result:         last_c};
                    m_valid_reg <= 1'b1;
                    state_reg   <= T_OUT;
                end
                T_OUT: begin
                    // Hold the word until taken, then advance or finish the graph.
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        if (m_data_reg.last_result) begin
                            count_reg   <= '0;
                            dropped_reg <= 1'b0;
                            state_reg   <= T_LOAD;
                        end else begin
                            k_reg     <= k_reg + ENT_W'(1);
                            state_reg <= T_RE;
                        end
                    end
                end
                default: state_reg <= T_LOAD;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("loading while a result is pending");
    a_done_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        walk_done |-> state_reg == T_WALK)
        else $error("walk finished outside walk phase");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count beyond store size");
    a_replay_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> CNT_W'(k_reg) < count_reg)
        else $error("replay index beyond stored entries");
endmodule
`default_nettype wire

[dv/graph_bridge_finder_core_test.sv]
// Self-checking bench for graph_bridge_finder_core: loads graphs as adjacency words,
// predicts bridge flags with its own depth-first lowlink walk and checks every result.
// Depends on gbf_pkg and the core RTL only.
`timescale 1ns / 1ps
module graph_bridge_finder_core_test;
    import gbf_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [4:0] src;
        logic [4:0] nb;
        logic       last;
        logic       has_expect;  // typed-in expectation for a single-result graph
        logic       exp_kept;
        logic       exp_ovf;
    } stim_row_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      cfg_wr_en = 1'b0;
    logic [5:0] cfg_wr_data = '0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    graph_bridge_finder_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Predictor copy of the block state.
    int unsigned vtx_limit = 32;
    logic [4:0]  graph_src [MAX_ENTRIES];
    logic [4:0]  graph_nb  [MAX_ENTRIES];
    int unsigned graph_len = 0;
    bit          graph_dropped = 0;
    int unsigned disc_ord [MAX_VERTICES];
    int unsigned low_ord  [MAX_VERTICES];
    int unsigned parent   [MAX_VERTICES];
    out_word_t   pending_results[$];

    int errors = 0;
    int cycle = 0;
    int idle_in_pct = 0, stall_out_pct = 0;
    bit hold_off = 0;

    // Depth-first walk with explicit stack; records order, lowlink and parent.
    task automatic run_lowlink_walk(int unsigned n);
        bit          seen [MAX_VERTICES];
        int unsigned stk_v [MAX_VERTICES];
        int unsigned stk_i [MAX_VERTICES];
        int unsigned depth, order, v, i, w, p;
        order = 0;
        for (int r = 0; r < MAX_VERTICES; r++) seen[r] = 0;
        for (int r = 0; r < n; r++) begin
            if (seen[r]) continue;
            parent[r] = r; disc_ord[r] = order; low_ord[r] = order;
            order++; seen[r] = 1;
            stk_v[0] = r; stk_i[0] = 0; depth = 1;
            while (depth > 0) begin
                v = stk_v[depth-1];
                i = stk_i[depth-1];
                while (i < graph_len && graph_src[i] != v) i++;
                if (i >= graph_len) begin
                    depth--;
                    if (depth > 0) begin
                        p = stk_v[depth-1];
                        if (low_ord[v] < low_ord[p]) low_ord[p] = low_ord[v];
                    end
                    continue;
                end
                stk_i[depth-1] = i + 1;
                w = graph_nb[i];
                if (w >= n) continue;
                if (seen[w]) begin
                    // a parallel edge back to the parent is not a back edge
                    if (parent[v] != w && disc_ord[w] < low_ord[v]) low_ord[v] = disc_ord[w];
                end else if (depth < MAX_VERTICES) begin
                    parent[w] = v; disc_ord[w] = order; low_ord[w] = order; order++;
                    seen[w] = 1;
                    stk_v[depth] = w; stk_i[depth] = 0; depth++;
                end
            end
        end
    endtask

    // Accept one word into the predicted store; on the last word queue the replay.
    task automatic predict_bridges(in_word_t wd);
        int unsigned n, a, b;
        out_word_t r;
        if (graph_len < MAX_ENTRIES) begin
            graph_src[graph_len] = wd.source_vertex;
            graph_nb[graph_len] = wd.neighbor_vertex;
            graph_len++;
        end else begin
            graph_dropped = 1;
        end
        if (!wd.last_entry) return;
        n = (vtx_limit > MAX_VERTICES) ? MAX_VERTICES : vtx_limit;
        run_lowlink_walk(n);
        for (int k = 0; k < graph_len; k++) begin
            a = graph_src[k]; b = graph_nb[k];
            r.source_vertex_out = 5'(a);
            r.neighbor_vertex_out = 5'(b);
            r.overflow = graph_dropped;
            r.last_result = (k + 1 == graph_len);
            if (a >= n || b >= n) r.kept = 1'b1;
            else if (parent[a] == b) r.kept = !(disc_ord[b] < low_ord[a]);
            else if (parent[b] == a) r.kept = !(disc_ord[a] < low_ord[b]);
            else r.kept = 1'b1;
            pending_results = {pending_results, r};
        end
        graph_len = 0;
        graph_dropped = 0;
    endtask

    task automatic note_mismatch(out_word_t exp_w, out_word_t got_w);
        errors++;
        if (errors <= 10) begin
            $display("mismatch at cycle %0d:", cycle);
            $display("  expected src=%0d nb=%0d kept=%0b ovf=%0b last=%0b",
                     exp_w.source_vertex_out, exp_w.neighbor_vertex_out, exp_w.kept,
                     exp_w.overflow, exp_w.last_result);
            $display("  got      src=%0d nb=%0d kept=%0b ovf=%0b last=%0b",
                     got_w.source_vertex_out, got_w.neighbor_vertex_out, got_w.kept,
                     got_w.overflow, got_w.last_result);
        end
    endtask

    // Cycle counter and timeout.
    always @(posedge aclk) begin
        cycle <= cycle + 1;
        if (cycle > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side: random stall, plus a long hold-off on request; check every word.
    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result word at cycle %0d", cycle);
            end else if (m_data !== pending_results[0]) begin
                note_mismatch(pending_results[0], m_data);
                void'(pending_results.pop_front());
            end else begin
                void'(pending_results.pop_front());
            end
        end
        m_ready <= !hold_off && ($urandom_range(99) >= stall_out_pct);
    end

    // Directed table: single-entry graphs have typed-in expectations; the rest rely
    // on the predictor.
    stim_row_t directed_rows[] = '{
        // self loop on vertex 0: never a bridge
        '{5'd0,  5'd0,  1'b1, 1'b1, 1'b1, 1'b0},
        // neighbor out of range at vertex_count 32 is impossible; lone edge 0-1 is a bridge
        '{5'd0,  5'd1,  1'b1, 1'b1, 1'b0, 1'b0},
        // extremes: vertex 31 to 31 self loop
        '{5'd31, 5'd31, 1'b1, 1'b1, 1'b1, 1'b0},
        // triangle 0-1-2: no bridges
        '{5'd0,  5'd1,  1'b0, 1'b0, 1'b0, 1'b0},
        '{5'd0,  5'd2,  1'b0, 1'b0, 1'b0, 1'b0},
        '{5'd1,  5'd0,  1'b0, 1'b0, 1'b0, 1'b0},
        '{5'd1,  5'd2,  1'b0, 1'b0, 1'b0, 1'b0},
        '{5'd2,  5'd0,  1'b0, 1'b0, 1'b0, 1'b0},
        '{5'd2,  5'd1,  1'b1, 1'b0, 1'b0, 1'b0},
        // doubled lone edge: both copies reported as bridges
        '{5'd3,  5'd4,  1'b0, 1'b0, 1'b0, 1'b0},
        '{5'd3,  5'd4,  1'b0, 1'b0, 1'b0, 1'b0},
        '{5'd4,  5'd3,  1'b0, 1'b0, 1'b0, 1'b0},
        '{5'd4,  5'd3,  1'b1, 1'b0, 1'b0, 1'b0},
        // unsorted sources, path 31-30-29 with a late entry for 31
        '{5'd30, 5'd29, 1'b0, 1'b0, 1'b0, 1'b0},
        '{5'd31, 5'd30, 1'b0, 1'b0, 1'b0, 1'b0},
        '{5'd29, 5'd30, 1'b0, 1'b0, 1'b0, 1'b0},
        '{5'd30, 5'd31, 1'b1, 1'b0, 1'b0, 1'b0}
    };

    // Offer one word and hold it until taken; drop valid only when idling.
    task automatic send_word(in_word_t wd);
        s_valid <= 1'b1;
        s_data <= wd;
        do @(posedge aclk); while (!s_ready);
        predict_bridges(wd);
        if ($urandom_range(99) < idle_in_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < idle_in_pct);
        end
    endtask

    // Write vertex_count once the block has drained.
    task automatic set_vertex_limit(int unsigned vc);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= vc[5:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        vtx_limit = vc;
    endtask

    // Random graph with mostly in-range, sorted sources; some noise.
    task automatic send_random_graph(int unsigned entries, int unsigned vmax);
        in_word_t wd;
        int unsigned s;
        s = 0;
        for (int k = 0; k < entries; k++) begin
            if ($urandom_range(9) == 0) wd.source_vertex = 5'($urandom);
            else begin
                if ($urandom_range(2) == 0 && s < vmax) s++;
                wd.source_vertex = 5'(s);
            end
            if ($urandom_range(9) == 0) wd.neighbor_vertex = 5'($urandom);
            else wd.neighbor_vertex = 5'($urandom_range(vmax));
            wd.last_entry = (k + 1 == entries);
            send_word(wd);
        end
    endtask

    initial begin
        in_word_t wd;
        int unsigned sent;
        out_word_t typed;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at reset setting (32 vertices), no idling.
        foreach (directed_rows[i]) begin
            wd.source_vertex = directed_rows[i].src;
            wd.neighbor_vertex = directed_rows[i].nb;
            wd.last_entry = directed_rows[i].last;
            send_word(wd);
            if (directed_rows[i].has_expect) begin
                typed = '{directed_rows[i].src, directed_rows[i].nb, directed_rows[i].exp_kept,
                          directed_rows[i].exp_ovf, 1'b1};
                pending_results[pending_results.size() - 1] = typed;
            end
        end

        // Smallest vertex count: everything but 0 is out of range; 0 means no vertex.
        set_vertex_limit(1);
        send_word('{5'd0, 5'd0, 1'b0});
        send_word('{5'd0, 5'd5, 1'b1});
        set_vertex_limit(0);
        send_word('{5'd2, 5'd3, 1'b1});
        set_vertex_limit(63);
        send_word('{5'd31, 5'd0, 1'b0});
        send_word('{5'd0, 5'd31, 1'b1});

        // Overflow: 66 words, then a second graph offered while the receiver holds
        // off long enough for the block to stall its input.
        set_vertex_limit(32);
        hold_off = 1;
        fork
            begin
                repeat (12000) @(posedge aclk);
                hold_off = 0;
            end
        join_none
        send_random_graph(66, 31);
        send_random_graph(6, 31);
        sent = 0;

        // Random phases over several vertex counts and idle mixes.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_in_pct = 0;  stall_out_pct = 0;  set_vertex_limit(8);  end
                1: begin idle_in_pct = 47; stall_out_pct = 0;  set_vertex_limit(32); end
                2: begin idle_in_pct = 0;  stall_out_pct = 47; set_vertex_limit(17); end
                default: begin idle_in_pct = 33; stall_out_pct = 33; set_vertex_limit(5); end
            endcase
            sent = 0;
            while (sent < 36) begin
                int unsigned len;
                if ($urandom_range(7) == 0) len = $urandom_range(30, 64);
                else len = $urandom_range(1, 12);
                send_random_graph(len, (vtx_limit > 31) ? 31 : vtx_limit);
                sent += len;
            end
        end

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
